// ----- hw/rtl/sukt_pkg.sv -----
// ----------------------------------------------------------------------------
// sukt_pkg
// Shared sizes, types and codes of the sorted unique key table.
// ----------------------------------------------------------------------------
package sukt_pkg;

  // table sizing
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  // one stored entry: flag beside the key
  typedef struct packed {
    logic flag;
    key_t key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // place codes
  localparam logic [1:0] PLACE_EMPTY = 2'd0;
  localparam logic [1:0] PLACE_HEAD  = 2'd1;
  localparam logic [1:0] PLACE_MID   = 2'd2;
  localparam logic [1:0] PLACE_TAIL  = 2'd3;

endpackage

// ----- hw/rtl/sukt_ram.sv -----
// ----------------------------------------------------------------------------
// sukt_ram
// Simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sukt_ram #(
  parameter int WIDTH  = 17,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/sorted_unique_key_table_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_unique_key_table_unit
// Table of unique signed keys in ascending order, each with a one-bit flag.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result
// appears for one cycle with out_valid high and cannot be held off. Keys and
// flags live in one RAM with a registered read. A binary search probes one
// entry a cycle, then a decide state follows. An insert of an absent key
// into a table that is not full then moves each entry at or above the rank
// up by one, one entry a cycle through the RAM's read and write ports, and
// an insert state writes the new entry. The result shows in the cycle after
// the last of these, when busy is already low again.
// ----------------------------------------------------------------------------
module sorted_unique_key_table_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  sukt_pkg::key_t        in_key,
  input  logic                  in_entry_flag,
  output logic                  out_valid,
  output logic                  out_hit,
  output logic                  out_added,
  output logic                  out_table_full,
  output logic [1:0]            out_place,
  output sukt_pkg::cnt_t        out_rank,
  output logic                  out_found_flag,
  output sukt_pkg::cnt_t        out_entry_count
);

  import sukt_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_INS    = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       kind_r, kind_nxt;
  key_t       key_r, key_nxt;
  logic       eflag_r, eflag_nxt;
  cnt_t       lo_r, lo_nxt;
  cnt_t       hi_r, hi_nxt;
  idx_t       mid_r, mid_nxt;
  idx_t       src_r, src_nxt;
  logic       hit_r, hit_nxt;
  logic       fflag_r, fflag_nxt;
  cnt_t       count_r, count_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_hit_r, out_hit_nxt;
  logic       out_added_r, out_added_nxt;
  logic       out_full_r, out_full_nxt;
  logic [1:0] out_place_r, out_place_nxt;
  cnt_t       out_rank_r, out_rank_nxt;
  logic       out_fflag_r, out_fflag_nxt;
  cnt_t       out_count_r, out_count_nxt;

  // ram controls
  logic   ram_wr_en;
  idx_t   ram_wr_addr;
  entry_t ram_wr_data;
  logic   ram_rd_en;
  idx_t   ram_rd_addr;
  entry_t ram_rd_data;

  sukt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // place code from rank and pre-insert count
  function automatic logic [1:0] place_of(input cnt_t rank, input cnt_t count);
    logic [1:0] p;
    if (count == '0) begin
      p = PLACE_EMPTY;
    end else if (rank == '0) begin
      p = PLACE_HEAD;
    end else if ((CNT_W+1)'(rank) + (CNT_W+1)'(1) >= (CNT_W+1)'(count)) begin
      p = PLACE_TAIL;
    end else begin
      p = PLACE_MID;
    end
    return p;
  endfunction

  // midpoint of the search window
  function automatic idx_t mid_of(input cnt_t lo, input cnt_t hi);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(lo) + (CNT_W+1)'(hi);
    return sum[IDX_W:1];
  endfunction

  // next state and datapath
  always_comb begin
    logic   do_ins;
    logic   do_full;
    logic   emit;
    logic   added;
    do_ins  = kind_r && !hit_r && (count_r != CNT_W'(CAPACITY));
    do_full = kind_r && !hit_r && (count_r == CNT_W'(CAPACITY));
    emit    = 1'b0;
    added   = 1'b0;

    state_nxt = state_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    eflag_nxt = eflag_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    src_nxt   = src_r;
    hit_nxt   = hit_r;
    fflag_nxt = fflag_r;
    count_nxt = count_r;

    ram_wr_en   = 1'b0;
    ram_wr_addr = src_r;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = mid_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          key_nxt   = in_key;
          eflag_nxt = in_entry_flag;
          hit_nxt   = 1'b0;
          fflag_nxt = 1'b0;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          if (count_r == '0) begin
            state_nxt = ST_DECIDE;
          end else begin
            mid_nxt     = mid_of('0, count_r);
            ram_rd_en   = 1'b1;
            ram_rd_addr = mid_nxt;
            state_nxt   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // read data belongs to mid_r
        if (ram_rd_data.key < key_r) begin
          lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
        end else begin
          hi_nxt = CNT_W'(mid_r);
          if (ram_rd_data.key == key_r) begin
            hit_nxt   = 1'b1;
            fflag_nxt = ram_rd_data.flag;
          end
        end
        if (lo_nxt < hi_nxt) begin
          mid_nxt     = mid_of(lo_nxt, hi_nxt);
          ram_rd_en   = 1'b1;
          ram_rd_addr = mid_nxt;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (do_ins) begin
          if (lo_r == count_r) begin
            state_nxt = ST_INS;
          end else begin
            src_nxt     = IDX_W'(count_r - CNT_W'(1));
            ram_rd_en   = 1'b1;
            ram_rd_addr = src_nxt;
            state_nxt   = ST_SHIFT;
          end
        end else begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        // move entry src_r up by one place
        ram_wr_en   = 1'b1;
        ram_wr_addr = IDX_W'(CNT_W'(src_r) + CNT_W'(1));
        ram_wr_data = ram_rd_data;
        if (CNT_W'(src_r) == lo_r) begin
          state_nxt = ST_INS;
        end else begin
          src_nxt     = src_r - IDX_W'(1);
          ram_rd_en   = 1'b1;
          ram_rd_addr = src_nxt;
        end
      end
      ST_INS: begin
        ram_wr_en        = 1'b1;
        ram_wr_addr      = lo_r[IDX_W-1:0];
        ram_wr_data.flag = eflag_r;
        ram_wr_data.key  = key_r;
        count_nxt        = count_r + CNT_W'(1);
        added            = 1'b1;
        emit             = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // result register
    out_valid_nxt = emit;
    out_hit_nxt   = out_hit_r;
    out_added_nxt = out_added_r;
    out_full_nxt  = out_full_r;
    out_place_nxt = out_place_r;
    out_rank_nxt  = out_rank_r;
    out_fflag_nxt = out_fflag_r;
    out_count_nxt = out_count_r;
    if (emit) begin
      out_hit_nxt   = hit_r;
      out_added_nxt = added;
      out_full_nxt  = do_full;
      out_place_nxt = place_of(lo_r, count_r);
      out_rank_nxt  = lo_r;
      out_fflag_nxt = fflag_r;
      out_count_nxt = count_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    eflag_r     <= eflag_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    src_r       <= src_nxt;
    hit_r       <= hit_nxt;
    fflag_r     <= fflag_nxt;
    out_hit_r   <= out_hit_nxt;
    out_added_r <= out_added_nxt;
    out_full_r  <= out_full_nxt;
    out_place_r <= out_place_nxt;
    out_rank_r  <= out_rank_nxt;
    out_fflag_r <= out_fflag_nxt;
    out_count_r <= out_count_nxt;
  end

  // outputs
  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_added       = out_added_r;
  assign out_table_full  = out_full_r;
  assign out_place       = out_place_r;
  assign out_rank        = out_rank_r;
  assign out_found_flag  = out_fflag_r;
  assign out_entry_count = out_count_r;

endmodule

// ----- hw/rtl/sukt_checker.sv -----
// ----------------------------------------------------------------------------
// sukt_checker
// Port-level checks of the sorted unique key table, bound to sorted_unique_key_table_unit.
// ----------------------------------------------------------------------------
module sukt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input logic           out_hit,
  input logic           out_added,
  input logic           out_table_full,
  input sukt_pkg::cnt_t out_entry_count
);

  import sukt_pkg::*;

  // an accepted transaction always raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result is shown only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // result strobes never come in back-to-back cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // an added key was neither present nor refused
  a_added_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_added) |-> (!out_hit && !out_table_full && out_entry_count != '0))
    else $error("added together with hit or full");

  // a refused insert leaves the table full
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_entry_count == CNT_W'(CAPACITY)))
    else $error("table_full with table not full");

endmodule

bind sorted_unique_key_table_unit sukt_checker u_sukt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_hit        (out_hit),
  .out_added      (out_added),
  .out_table_full (out_table_full),
  .out_entry_count(out_entry_count)
);
